>>> design/rnf_pkg.sv
// ----------------------------------------------------------------------------
// rnf_pkg - radix number formatter shared definitions
// Widths, register indexes, reset values and the control/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package rnf_pkg;

  // Fixed field widths
  localparam int NUM_PORT_W  = 32;   // width of the number field on the port
  localparam int SYM_W       = 8;    // one output byte
  localparam int RADIX_W     = 6;    // radix register
  localparam int CFG_DATA_W  = 64;   // widest register
  localparam int CFG_INDEX_W = 3;

  // Symbol table: 32 bytes held in four 64-bit registers
  localparam int NUM_SYMS    = 32;
  localparam int SYM_ADDR_W  = 5;

  // Digit buffer
  localparam int BUF_DEPTH   = 32;
  localparam int BUF_AW      = 5;
  localparam int COUNT_W     = 6;

  // Quotient bits resolved per divider cycle
  localparam int DIV_BITS    = 4;

  // Parameter defaults
  localparam int DEF_MAX_RADIX    = 32;
  localparam int DEF_NUMBER_WIDTH = 32;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RADIX  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA3 = 3'd4;

  // Reset values: radix 10, symbols "0123456789"
  localparam logic [RADIX_W-1:0]    RADIX_RESET  = 6'd10;
  localparam logic [CFG_DATA_W-1:0] ALPHA0_RESET = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] ALPHA1_RESET = 64'h0000_0000_0000_3938;
  localparam logic [CFG_DATA_W-1:0] ALPHA2_RESET = 64'h0;
  localparam logic [CFG_DATA_W-1:0] ALPHA3_RESET = 64'h0;

  // Character codes
  localparam logic [SYM_W-1:0]   SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0]   SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0]   SYM_NONE  = 8'h00;
  localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // capture the accepted number, clear counters
    logic check;      // test one alphabet symbol
    logic div_step;   // one divider cycle
    logic put_err;    // load the invalid-alphabet result
    logic put_sign;   // load '-'
    logic put_digit;  // load the next digit symbol, pop the buffer
  } rnf_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic check_bad;   // radix out of range or current symbol rejected
    logic check_last;  // current symbol is the last one in use
    logic div_last;    // final cycle of the current digit
    logic div_stop;    // no digit follows the current one
    logic negative;    // captured number was negative
    logic emit_last;   // one digit left in the buffer
    logic out_free;    // output register can take a result
  } rnf_status_t;

endpackage

>>> design/rnf_if.sv
// ----------------------------------------------------------------------------
// rnf_if - request channels of the radix number formatter
// rnf_num_if carries numbers in, rnf_sym_if carries formatted symbols out.
// ----------------------------------------------------------------------------
interface rnf_num_if;
  import rnf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [NUM_PORT_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface rnf_sym_if;
  import rnf_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;
  logic             invalid;

  modport source (output valid, output symbol, output last, output invalid, input ready);
  modport sink   (input valid, input symbol, input last, input invalid, output ready);
endinterface

>>> design/rnf_ctrl.sv
// ----------------------------------------------------------------------------
// rnf_ctrl - formatter sequencer
// Walks each request through alphabet check, then the invalid result or
// division, optional sign and digits; drives the datapath by command bundle.
// ----------------------------------------------------------------------------
module rnf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rnf_pkg::rnf_status_t status,
  output rnf_pkg::rnf_cmd_t    cmd
);
  import rnf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_DIV     = 7'b0000100,
    S_SIGN    = 7'b0001000,
    S_EMIT_RD = 7'b0010000,
    S_EMIT    = 7'b0100000,
    S_ERR     = 7'b1000000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (status.check_bad) begin
          state_next = S_ERR;
        end else if (status.check_last) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last && status.div_stop) begin
          state_next = status.negative ? S_SIGN : S_EMIT_RD;
        end
      end
      S_SIGN: begin
        if (status.out_free) begin
          cmd.put_sign = 1'b1;
          state_next   = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        // buffer read address settles, data registered for S_EMIT
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.put_digit = 1'b1;
          state_next    = status.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_ERR: begin
        if (status.out_free) begin
          cmd.put_err = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/rnf_datapath.sv
// ----------------------------------------------------------------------------
// rnf_datapath - formatter registers, divider, digit buffer and output stage
// Holds the configuration, checks the alphabet one symbol per cycle, divides
// the magnitude by the radix DIV_BITS quotient bits per cycle, stores digits
// least significant first and hands symbols out through a register.
// ----------------------------------------------------------------------------
module rnf_datapath #(
  parameter int MAX_RADIX    = rnf_pkg::DEF_MAX_RADIX,
  parameter int NUMBER_WIDTH = rnf_pkg::DEF_NUMBER_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [rnf_pkg::CFG_INDEX_W-1:0]      wr_index,
  input  logic [rnf_pkg::CFG_DATA_W-1:0]       wr_data,
  input  logic signed [rnf_pkg::NUM_PORT_W-1:0] number,
  input  rnf_pkg::rnf_cmd_t                    cmd,
  output rnf_pkg::rnf_status_t                 status,
  rnf_sym_if.source                            symbols
);
  import rnf_pkg::*;

  localparam int DIG_W      = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int MAG_W      = ((NUMBER_WIDTH + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_CYCLES = MAG_W / DIV_BITS;
  localparam int CYC_W      = $clog2(DIV_CYCLES);

  // Configuration
  logic [RADIX_W-1:0]    radix;
  logic [CFG_DATA_W-1:0] alpha0, alpha1, alpha2, alpha3;
  logic [NUM_SYMS*SYM_W-1:0] alpha_bytes;

  // Working registers
  logic [DIG_W-1:0]   chk_idx;
  logic [MAG_W-1:0]   quo;
  logic [DIG_W-1:0]   rem;
  logic [CYC_W-1:0]   cyc;
  logic [COUNT_W-1:0] count;
  logic               negative;
  logic [DIG_W-1:0]   digit_mem [BUF_DEPTH];
  logic [DIG_W-1:0]   digit_q;

  // Output register
  logic             out_valid;
  logic [SYM_W-1:0] out_symbol;
  logic             out_last;
  logic             out_invalid;

  // Combinational
  logic [NUMBER_WIDTH-1:0] raw;
  logic [NUMBER_WIDTH-1:0] mag;
  logic [SYM_ADDR_W-1:0]   sym_addr;
  logic [SYM_W-1:0]        sym;
  logic                    dup;
  logic                    range_bad;
  logic [MAG_W-1:0]        quo_next;
  logic [DIG_W-1:0]        rem_next;
  logic [COUNT_W-1:0]      count_m1;
  logic [BUF_AW-1:0]       rd_addr;
  logic                    out_free;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      radix  <= RADIX_RESET;
      alpha0 <= ALPHA0_RESET;
      alpha1 <= ALPHA1_RESET;
      alpha2 <= ALPHA2_RESET;
      alpha3 <= ALPHA3_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RADIX:  radix  <= wr_data[RADIX_W-1:0];
        REG_ALPHA0: alpha0 <= wr_data;
        REG_ALPHA1: alpha1 <= wr_data;
        REG_ALPHA2: alpha2 <= wr_data;
        REG_ALPHA3: alpha3 <= wr_data;
        default: ;
      endcase
    end
  end

  assign alpha_bytes = {alpha3, alpha2, alpha1, alpha0};

  // Symbol lookup: check index while checking, buffered digit while emitting
  assign sym_addr = cmd.check ? SYM_ADDR_W'(chk_idx) : SYM_ADDR_W'(digit_q);
  assign sym      = alpha_bytes[sym_addr*SYM_W +: SYM_W];

  // Compare the current symbol against every earlier one in use
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < MAX_RADIX; j++) begin
      if ((j < int'(chk_idx)) && (alpha_bytes[j*SYM_W +: SYM_W] == sym)) begin
        dup = 1'b1;
      end
    end
  end

  assign range_bad = (radix < MIN_RADIX) || (radix > RADIX_W'(MAX_RADIX));

  // Magnitude of the low NUMBER_WIDTH bits
  assign raw = number[NUMBER_WIDTH-1:0];
  assign mag = raw[NUMBER_WIDTH-1] ? (~raw + NUMBER_WIDTH'(1)) : raw;

  // Restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [DIG_W:0]   rem_w;
    logic [DIG_W:0]   div_w;
    logic [MAG_W-1:0] quo_w;
    rem_w = {1'b0, rem};
    div_w = radix[DIG_W:0];
    quo_w = quo;
    for (int k = 0; k < DIV_BITS; k++) begin
      rem_w = {rem_w[DIG_W-1:0], quo_w[MAG_W-1]};
      quo_w = {quo_w[MAG_W-2:0], 1'b0};
      if (rem_w >= div_w) begin
        rem_w    = rem_w - div_w;
        quo_w[0] = 1'b1;
      end
    end
    quo_next = quo_w;
    rem_next = rem_w[DIG_W-1:0];
  end

  // Check index, divider and digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= '0;
    end else if (cmd.div_step && (cyc == CYC_W'(DIV_CYCLES - 1))) begin
      count <= count + COUNT_W'(1);
    end else if (cmd.put_digit) begin
      count <= count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chk_idx  <= '0;
      quo      <= MAG_W'(mag);
      rem      <= '0;
      cyc      <= '0;
      negative <= raw[NUMBER_WIDTH-1];
    end else if (cmd.check) begin
      chk_idx <= chk_idx + DIG_W'(1);
    end else if (cmd.div_step) begin
      quo <= quo_next;
      if (cyc == CYC_W'(DIV_CYCLES - 1)) begin
        rem <= '0;
        cyc <= '0;
      end else begin
        rem <= rem_next;
        cyc <= cyc + CYC_W'(1);
      end
    end
  end

  // Digit buffer: written at the count, read at count-1
  assign count_m1 = count - COUNT_W'(1);
  assign rd_addr  = count_m1[BUF_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_step && (cyc == CYC_W'(DIV_CYCLES - 1))) begin
      digit_mem[count[BUF_AW-1:0]] <= rem_next;
    end
    digit_q <= digit_mem[rd_addr];
  end

  // Output register
  assign out_free = !out_valid || symbols.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put_err || cmd.put_sign || cmd.put_digit) begin
      out_valid <= 1'b1;
    end else if (symbols.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_err) begin
      out_symbol  <= SYM_NONE;
      out_last    <= 1'b1;
      out_invalid <= 1'b1;
    end else if (cmd.put_sign) begin
      out_symbol  <= SYM_MINUS;
      out_last    <= 1'b0;
      out_invalid <= 1'b0;
    end else if (cmd.put_digit) begin
      out_symbol  <= sym;
      out_last    <= (count == COUNT_W'(1));
      out_invalid <= 1'b0;
    end
  end

  assign symbols.valid   = out_valid;
  assign symbols.symbol  = out_symbol;
  assign symbols.last    = out_last;
  assign symbols.invalid = out_invalid;

  // Status
  assign status.check_bad  = range_bad || (sym == SYM_NONE) || (sym == SYM_PLUS) ||
                             (sym == SYM_MINUS) || dup;
  assign status.check_last = (RADIX_W'(chk_idx) == (radix - RADIX_W'(1)));
  assign status.div_last   = (cyc == CYC_W'(DIV_CYCLES - 1));
  assign status.div_stop   = (quo_next == '0) || (count == COUNT_W'(BUF_DEPTH - 1));
  assign status.negative   = negative;
  assign status.emit_last  = (count == COUNT_W'(1));
  assign status.out_free   = out_free;

  // Results are only loaded into a free output register
  a_put_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.put_err || cmd.put_sign || cmd.put_digit) |-> out_free)
    else $error("result loaded over a held result");

  // Digit count stays within the buffer
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(BUF_DEPTH))
    else $error("digit count past buffer depth");

  // Partial remainder stays below the radix while dividing
  a_rem_lt: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (RADIX_W'(rem) < radix))
    else $error("remainder not below radix");

  // Emitting the final digit empties the buffer
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.put_digit && status.emit_last) |=> (count == '0))
    else $error("buffer not empty after final digit");

endmodule

>>> design/radix_number_formatter.sv
// ----------------------------------------------------------------------------
// radix_number_formatter - signed integer to text in a configured radix
// Formats each number as alphabet symbols, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   numbers : one request per signed number (low NUMBER_WIDTH bits used).
//   symbols : one request per output byte; last marks a number's final byte.
//             A negative number starts with '-'. If the radix is outside
//             2..MAX_RADIX or the alphabet holds 0, '+', '-' or a repeated
//             symbol among the first radix entries, the number yields a
//             single request with symbol 0, last and invalid set.
//   wr_en/wr_index/wr_data : register writes (radix, alphabet_0..3); write
//             only while no number is in flight.
// Per number, in order: accept, then the alphabet check (one symbol per
// cycle, at most radix symbols), then the division, repeated for each
// digit (4 quotient bits per cycle), then the sign if negative, then for
// each digit a buffer read and an output load. Sign and digit loads wait
// while the output register still holds an unaccepted symbol.
// The next number is accepted once the last symbol is in the output register.
// Reset restores radix 10 and symbols "0".."9" and empties the output stage.
// A stalled receiver holds the current symbol; the sequencer waits with it.
// ----------------------------------------------------------------------------
module radix_number_formatter #(
  parameter int MAX_RADIX    = rnf_pkg::DEF_MAX_RADIX,
  parameter int NUMBER_WIDTH = rnf_pkg::DEF_NUMBER_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [rnf_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [rnf_pkg::CFG_DATA_W-1:0]  wr_data,
  rnf_num_if.sink                         numbers,
  rnf_sym_if.source                       symbols
);
  import rnf_pkg::*;

  rnf_cmd_t    cmd;
  rnf_status_t status;
  logic        in_ready;

  // Sequencer
  rnf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (numbers.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign numbers.ready = in_ready;

  // Registers, divider, buffer and output stage
  rnf_datapath #(
    .MAX_RADIX    (MAX_RADIX),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .number   (numbers.number),
    .cmd      (cmd),
    .status   (status),
    .symbols  (symbols)
  );

endmodule

>>> verif/rnf_checker.sv
// ----------------------------------------------------------------------------
// rnf_checker - symbol stream predictor and scoreboard
// Mirrors the register writes, works out the symbols each accepted number
// must produce and compares every accepted symbol request with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module rnf_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [rnf_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [rnf_pkg::CFG_DATA_W-1:0]  wr_data,
  rnf_num_if                              num_ch,
  rnf_sym_if                              sym_ch,
  output int                              errors,
  output int                              pending,
  output int                              numbers_seen,
  output int                              symbols_seen,
  output int                              invalid_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import rnf_pkg::*;

  // Power-up format: base 10, digits "0".."9"
  localparam logic [5:0]   BASE_RESET    = 6'd10;
  localparam logic [255:0] SYMBOLS_RESET = {128'h0, 64'h3938, "76543210"};

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             invalid;
  } symbol_req_t;

  logic [5:0]   base;
  logic [255:0] symbols_cfg;
  symbol_req_t  expected_q[$];

  function automatic logic [7:0] symbol_for(input int digit);
    return symbols_cfg[digit*8 +: 8];
  endfunction

  // Base in range, no reserved byte and no repeat among the symbols in use
  function automatic bit format_ok();
    logic [7:0] s;
    if (base < 2 || base > 32) return 1'b0;
    for (int i = 0; i < base; i++) begin
      s = symbol_for(i);
      if (s == SYM_NONE || s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
      for (int j = 0; j < i; j++)
        if (symbol_for(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the symbol requests one number must produce
  function automatic void predict_symbols(input logic [31:0] value);
    logic [32:0] mag;
    logic [4:0]  digits [32];
    int          count;
    bit          negative;
    if (!format_ok()) begin
      expected_q.push_back('{symbol: SYM_NONE, last: 1'b1, invalid: 1'b1});
      return;
    end
    negative = value[31];
    // one bit wider so the most negative value keeps its magnitude
    mag = negative ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
    count = 0;
    do begin
      digits[count] = 5'(mag % base);
      mag = mag / base;
      count++;
    end while (mag != 0 && count < 32);
    if (negative)
      expected_q.push_back('{symbol: SYM_MINUS, last: 1'b0, invalid: 1'b0});
    for (int k = count - 1; k >= 0; k--)
      expected_q.push_back('{symbol: symbol_for(int'(digits[k])), last: (k == 0),
                             invalid: 1'b0});
  endfunction

  always @(posedge clk) begin
    symbol_req_t got;
    symbol_req_t want;
    if (rst) begin
      base         = BASE_RESET;
      symbols_cfg  = SYMBOLS_RESET;
      expected_q.delete();
      errors       = 0;
      numbers_seen = 0;
      symbols_seen = 0;
      invalid_seen = 0;
    end else begin
      // compare outgoing symbols first: a new number never owns them
      if (sym_ch.valid && sym_ch.ready) begin
        got = '{symbol: sym_ch.symbol, last: sym_ch.last, invalid: sym_ch.invalid};
        symbols_seen++;
        if (got.invalid === 1'b1) invalid_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected symbol request: expected none, got %h/%b/%b",
                   $time, got.symbol, got.last, got.invalid);
        end else begin
          want = expected_q.pop_front();
          if (got.symbol !== want.symbol || got.last !== want.last ||
              got.invalid !== want.invalid) begin
            errors++;
            $display("%0t ns: symbol mismatch: expected %h/%b/%b got %h/%b/%b",
                     $time, want.symbol, want.last, want.invalid,
                     got.symbol, got.last, got.invalid);
          end
        end
      end

      if (num_ch.valid && num_ch.ready) begin
        numbers_seen++;
        predict_symbols(num_ch.number);
      end

      // register mirror; unknown indexes are dropped
      if (wr_en) begin
        case (wr_index)
          REG_RADIX:  base                 = wr_data[5:0];
          REG_ALPHA0: symbols_cfg[63:0]    = wr_data;
          REG_ALPHA1: symbols_cfg[127:64]  = wr_data;
          REG_ALPHA2: symbols_cfg[191:128] = wr_data;
          REG_ALPHA3: symbols_cfg[255:192] = wr_data;
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> verif/tb_radix_number_formatter.sv
// ----------------------------------------------------------------------------
// tb_radix_number_formatter - testbench top for the radix number formatter
// Drives numbers and register writes, paces the symbol receiver through
// several stall modes including one long hold-off, and reports the verdict
// from the checker's error count.
// ----------------------------------------------------------------------------
module tb_radix_number_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  import rnf_pkg::*;

  localparam int CLK_PERIOD        = 12;
  localparam int RESET_CYCLES      = 10;
  localparam int HOLD_OFF_CYCLES   = 400;
  localparam int SETTLE_CYCLES     = 8;
  localparam int TAIL_CYCLES       = 400;
  localparam int RUN_LIMIT_NS      = 10_000_000;
  localparam int FORMATS_PER_PHASE = 3;
  localparam int ITEMS_PER_FORMAT  = 11;

  // Unmapped register index, writes to it must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  // Alphabet words, digit 0 in the low byte
  localparam logic [63:0] DEC_LO = "76543210";
  localparam logic [63:0] DEC_HI = 64'h3938;
  localparam logic [63:0] HEX_HI = "FEDCBA98";
  localparam logic [63:0] B32_2  = "NMLKJIHG";
  localparam logic [63:0] B32_3  = "VUTSRQPO";

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  rnf_num_if num_ch ();
  rnf_sym_if sym_ch ();

  int send_gap_pct;
  int stall_pct;
  bit hold_off_req;
  int cur_radix;

  int errors;
  int pending;
  int numbers_seen;
  int symbols_seen;
  int invalid_seen;

  radix_number_formatter u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .numbers  (num_ch),
    .symbols  (sym_ch)
  );

  rnf_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .num_ch       (num_ch),
    .sym_ch       (sym_ch),
    .errors       (errors),
    .pending      (pending),
    .numbers_seen (numbers_seen),
    .symbols_seen (symbols_seen),
    .invalid_seen (invalid_seen)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // Symbol receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        sym_ch.ready <= 1'b0;
      end else begin
        sym_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [63:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= data;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  // Stop offering and wait until every predicted symbol has come out
  task automatic drain_requests();
    @(negedge clk);
    num_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_format(input logic [63:0] radix_word, input logic [63:0] a0,
                             input logic [63:0] a1, input logic [63:0] a2,
                             input logic [63:0] a3);
    drain_requests();
    write_reg(REG_RADIX, radix_word);
    write_reg(REG_ALPHA0, a0);
    write_reg(REG_ALPHA1, a1);
    write_reg(REG_ALPHA2, a2);
    write_reg(REG_ALPHA3, a3);
    cur_radix = int'(radix_word[5:0]);
  endtask

  // Offer one number, with random idle cycles ahead of it
  task automatic offer_number(input logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      num_ch.valid <= 1'b0;
      @(negedge clk);
    end
    num_ch.valid  <= 1'b1;
    num_ch.number <= value;
    do @(posedge clk); while (!num_ch.ready);
  endtask

  // 32 distinct printable-or-not bytes, never 0, '+' or '-'
  task automatic make_alphabet(output logic [255:0] sym_bytes);
    bit         taken [256];
    logic [7:0] b;
    taken = '{default: 1'b0};
    taken[SYM_NONE]  = 1'b1;
    taken[SYM_PLUS]  = 1'b1;
    taken[SYM_MINUS] = 1'b1;
    for (int i = 0; i < 32; i++) begin
      do b = 8'($urandom_range(1, 255)); while (taken[b]);
      taken[b] = 1'b1;
      sym_bytes[i*8 +: 8] = b;
    end
  endtask

  // Random base and alphabet; about one in five is broken on purpose
  task automatic apply_random_format();
    logic [255:0] sym_bytes;
    logic [63:0]  radix_word;
    int           r;
    int           pos;
    int           kind;
    make_alphabet(sym_bytes);
    case ($urandom_range(0, 9))
      0:       r = 2;
      1:       r = 32;
      default: r = $urandom_range(3, 31);
    endcase
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      pos = $urandom_range(0, r - 1);
      case ($urandom_range(0, 3))
        0:       sym_bytes[pos*8 +: 8] = SYM_NONE;
        1:       sym_bytes[pos*8 +: 8] = SYM_PLUS;
        2:       sym_bytes[pos*8 +: 8] = SYM_MINUS;
        default: sym_bytes[pos*8 +: 8] = sym_bytes[((pos + 1) % r)*8 +: 8];
      endcase
    end else if (kind == 1) begin
      case ($urandom_range(0, 2))
        0:       r = 0;
        1:       r = 1;
        default: r = $urandom_range(33, 63);
      endcase
    end
    // upper bits of the radix write are junk the block must ignore
    radix_word      = {$urandom, $urandom};
    radix_word[5:0] = r[5:0];
    load_format(radix_word, sym_bytes[63:0], sym_bytes[127:64],
                sym_bytes[191:128], sym_bytes[255:192]);
  endtask

  // Mix of full-range, small, extreme and near-power-of-base numbers
  function automatic logic [31:0] pick_number();
    longint      p;
    int          k;
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: begin
        v = $urandom_range(0, 40);
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        p = 1;
        k = $urandom_range(0, 31);
        if (cur_radix >= 2 && cur_radix <= 32)
          repeat (k) if (p * cur_radix <= 64'h8000_0000) p = p * cur_radix;
        v = p[31:0] - $urandom_range(0, 1);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Main sequence
  initial begin
    rst           = 1'b1;
    wr_en         = 1'b0;
    wr_index      = '0;
    wr_data       = '0;
    num_ch.valid  = 1'b0;
    num_ch.number = '0;
    sym_ch.ready  = 1'b0;
    send_gap_pct  = 0;
    stall_pct     = 0;
    hold_off_req  = 1'b0;
    cur_radix     = 10;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // power-up decimal format
    offer_number(32'd0);
    offer_number(32'd7);
    offer_number(-32'sd1);
    offer_number(32'd10);
    offer_number(32'h7FFF_FFFF);
    offer_number(32'h8000_0000);
    offer_number(-32'sd909);

    // binary, radix write carrying junk in the upper bits
    load_format(64'hFFFF_FFFF_FFFF_FFC2, DEC_LO, DEC_HI, 64'h0, 64'h0);
    offer_number(32'h8000_0000);
    offer_number(32'h7FFF_FFFF);
    offer_number(32'd5);

    // hexadecimal
    load_format(64'd16, DEC_LO, HEX_HI, 64'h0, 64'h0);
    offer_number(32'hDEAD_BEEF);
    offer_number(32'd255);
    offer_number(32'd0);

    // base 32, every alphabet word in use
    load_format(64'd32, DEC_LO, HEX_HI, B32_2, B32_3);
    offer_number(32'h8000_0000);
    offer_number(32'h7FFF_FFFF);

    // radix out of range
    load_format(64'd0, DEC_LO, HEX_HI, B32_2, B32_3);
    offer_number(32'd12345);
    load_format(64'd1, DEC_LO, HEX_HI, B32_2, B32_3);
    offer_number(-32'sd12345);
    load_format(64'd33, DEC_LO, HEX_HI, B32_2, B32_3);
    offer_number(32'd1);
    load_format(64'd63, DEC_LO, HEX_HI, B32_2, B32_3);
    offer_number(32'h8000_0000);

    // reserved byte or repeat in the top symbol slot
    load_format(64'd32, DEC_LO, HEX_HI, B32_2, {SYM_PLUS, B32_3[55:0]});
    offer_number(32'd99);
    load_format(64'd32, DEC_LO, HEX_HI, B32_2, {SYM_MINUS, B32_3[55:0]});
    offer_number(-32'sd99);
    load_format(64'd32, DEC_LO, HEX_HI, B32_2, {SYM_NONE, B32_3[55:0]});
    offer_number(32'd31);
    load_format(64'd32, DEC_LO, HEX_HI, B32_2, {B32_3[55:48], B32_3[55:0]});
    offer_number(32'd32);

    // write to an unmapped index leaves base 32 in place
    load_format(64'd32, DEC_LO, HEX_HI, B32_2, B32_3);
    write_reg(REG_SPARE, 64'd2);
    offer_number(-32'sd1000000);

    // random formats and numbers under four pacing modes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_gap_pct = 0;  stall_pct = 0;  end
        1:       begin send_gap_pct = 59; stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  stall_pct = 59; end
        default: begin send_gap_pct = 24; stall_pct = 24; end
      endcase
      for (int f = 0; f < FORMATS_PER_PHASE; f++) begin
        apply_random_format();
        for (int i = 0; i < ITEMS_PER_FORMAT; i++) begin
          offer_number(pick_number());
          // long receiver hold-off while numbers keep coming
          if (phase == 0 && f == 0 && i == 2) hold_off_req = 1'b1;
        end
      end
    end

    drain_requests();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Checked %0d numbers as %0d symbol requests (%0d invalid-format replies),",
             numbers_seen, symbols_seen, invalid_seen);
    $display("bases 2 to 32, out-of-range bases, broken alphabets and four pacing modes.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
